>>> design/twcw_pkg.sv
package twcw_pkg;

   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 128;

   // Wide enough to compare any register value or target with any window size.
   localparam int WIN_CMP_W = 9;

   localparam int CMD_W  = 3;
   localparam int CHAR_W = 8;
   localparam int ROW_W  = 6;
   localparam int COL_W  = 7;

   localparam logic [CMD_W-1:0] CMD_WRITE_CHAR = 3'd0;
   localparam logic [CMD_W-1:0] CMD_MOVE       = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR_EOL  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_BOX        = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ       = 3'd5;

   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'd13;
   localparam logic [CHAR_W-1:0] CH_LF     = 8'd10;
   localparam logic [CHAR_W-1:0] BOX_VLINE = 8'd179;
   localparam logic [CHAR_W-1:0] BOX_HLINE = 8'd196;
   localparam logic [CHAR_W-1:0] BOX_UL    = 8'd218;
   localparam logic [CHAR_W-1:0] BOX_LR    = 8'd217;
   localparam logic [CHAR_W-1:0] BOX_UR    = 8'd191;
   localparam logic [CHAR_W-1:0] BOX_LL    = 8'd192;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_ENABLE = 2'd2;

   localparam logic [6:0] ROWS_RESET   = 7'd25;
   localparam logic [7:0] COLS_RESET   = 8'd80;
   localparam logic       SCROLL_RESET = 1'b1;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [CHAR_W-1:0] char_code;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_W-1:0] cell_value;
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_col;
   } rsp_payload_type;

   typedef struct packed {
      logic [6:0] rows_in_use;
      logic [7:0] cols_in_use;
      logic       scroll_enable;
   } csr_type;

endpackage

>>> design/twcw_ifs.sv
interface twcw_req_if;
   import twcw_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface twcw_rsp_if;
   import twcw_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> design/text_window_character_writer_top.sv
// Text window character writer.
// Commands arrive as words on req_if (valid/ready): write character, move
// cursor, clear to end of line, erase, draw box and read cell. Every command
// returns exactly one word on rsp_if with the read cell value (zero for other
// commands) and the cursor position after the command.
// The window size and scroll mode are set through csr_we/csr_index/csr_wdata;
// the user must set them only while the block is idle, and the block itself
// does not enforce this. Index 0 is rows, 1 is columns, 2 is scroll enable.
// A character write, move, read or unused command loads its result from the
// execute state into the output register when that is free; no new word is
// taken until a command is done. Longer commands use the store's single write
// port and load the result from a done state: clear to end of line, box and
// erase (all MAX_ROWS * MAX_COLS cells) write one cell per cycle, and a scroll
// moves rows up with a read and a write of the same memory per moved cell.
// After reset the store is blanked to spaces, one cell per cycle, with
// req_if.ready low; the cursor resets to 0,0. A stalled receiver holds the
// result in the output register; one more word is taken and executed
// meanwhile, and its result waits for the register.
module text_window_character_writer_top #(
   parameter int MAX_ROWS = twcw_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = twcw_pkg::DEF_MAX_COLS
) (
   input  logic                                clock,
   input  logic                                reset,
   twcw_req_if.sink                            req_if,
   twcw_rsp_if.source                          rsp_if,
   input  logic                                csr_we,
   input  logic [twcw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [twcw_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import twcw_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);

   csr_type csr_ff, csr_in;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [CHAR_W-1:0] mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [CHAR_W-1:0] mem_rdata;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS_IN_USE:   csr_in.rows_in_use   = csr_wdata[6:0];
            CSR_COLS_IN_USE:   csr_in.cols_in_use   = csr_wdata[7:0];
            CSR_SCROLL_ENABLE: csr_in.scroll_enable = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.rows_in_use   <= ROWS_RESET;
         csr_ff.cols_in_use   <= COLS_RESET;
         csr_ff.scroll_enable <= SCROLL_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   twcw_cell_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   twcw_ctrl #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr       (csr_ff),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

endmodule

>>> design/twcw_cell_mem.sv
module twcw_cell_mem #(
   parameter int DEPTH = twcw_pkg::DEF_MAX_ROWS * twcw_pkg::DEF_MAX_COLS
) (
   input  logic                          clock,
   input  logic                          we,
   input  logic [$clog2(DEPTH)-1:0]      waddr,
   input  logic [twcw_pkg::CHAR_W-1:0]   wdata,
   input  logic [$clog2(DEPTH)-1:0]      raddr,
   output logic [twcw_pkg::CHAR_W-1:0]   rdata
);
   import twcw_pkg::*;

   logic [CHAR_W-1:0] store_mem [DEPTH];
   logic [CHAR_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= store_mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/twcw_ctrl.sv
module twcw_ctrl #(
   parameter int MAX_ROWS = twcw_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = twcw_pkg::DEF_MAX_COLS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   twcw_req_if.sink                                  req_if,
   twcw_rsp_if.source                                rsp_if,
   input  twcw_pkg::csr_type                         csr,
   output logic                                      mem_we,
   output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]      mem_waddr,
   output logic [twcw_pkg::CHAR_W-1:0]               mem_wdata,
   output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]      mem_raddr,
   input  logic [twcw_pkg::CHAR_W-1:0]               mem_rdata
);
   import twcw_pkg::*;

   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0] COLS_A = AW'(MAX_COLS);
   localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_EXEC   = 8'b0000_0010,
      ST_CLEAR  = 8'b0000_0100,
      ST_SCR_RD = 8'b0000_1000,
      ST_SCR_WR = 8'b0001_0000,
      ST_BLANK  = 8'b0010_0000,
      ST_BOX    = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   typedef enum logic [5:0] {
      BX_VERT = 6'b00_0001,
      BX_HORZ = 6'b00_0010,
      BX_UL   = 6'b00_0100,
      BX_UR   = 6'b00_1000,
      BX_LL   = 6'b01_0000,
      BX_LR   = 6'b10_0000
   } box_phase_type;

   state_type       state_ff, state_in;
   box_phase_type   phase_ff, phase_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   cur_y_ff, cur_y_in;
   logic [CW-1:0]   cur_x_ff, cur_x_in;
   logic [RW-1:0]   cnt_r_ff, cnt_r_in;
   logic [CW-1:0]   cnt_c_ff, cnt_c_in;
   logic [AW-1:0]   sweep_ff, sweep_in;
   logic            side_ff, side_in;
   logic            boot_ff, boot_in;
   logic [CHAR_W-1:0] cell_ff, cell_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [RW-1:0] last_row, cy_c, row_c, ny;
   logic [CW-1:0] last_col, cx_c, col_c, nx;
   logic accept, out_free, load_rsp, finish, go_scroll;

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
      return AW'(r) * COLS_A + AW'(c);
   endfunction

   // Effective window: zero acts as one, anything above the store acts as its size.
   always_comb begin
      if (csr.rows_in_use == '0) begin
         last_row = '0;
      end else if (WIN_CMP_W'(csr.rows_in_use) > WIN_CMP_W'(MAX_ROWS)) begin
         last_row = RW'(MAX_ROWS - 1);
      end else begin
         last_row = RW'(csr.rows_in_use - 1'b1);
      end
      if (csr.cols_in_use == '0) begin
         last_col = '0;
      end else if (WIN_CMP_W'(csr.cols_in_use) > WIN_CMP_W'(MAX_COLS)) begin
         last_col = CW'(MAX_COLS - 1);
      end else begin
         last_col = CW'(csr.cols_in_use - 1'b1);
      end
   end

   assign cy_c  = (WIN_CMP_W'(cur_y_ff) > WIN_CMP_W'(last_row)) ? last_row : cur_y_ff;
   assign cx_c  = (WIN_CMP_W'(cur_x_ff) > WIN_CMP_W'(last_col)) ? last_col : cur_x_ff;
   assign row_c = (WIN_CMP_W'(req_if.payload.row) > WIN_CMP_W'(last_row)) ?
                  last_row : RW'(req_if.payload.row);
   assign col_c = (WIN_CMP_W'(req_if.payload.col) > WIN_CMP_W'(last_col)) ?
                  last_col : CW'(req_if.payload.col);

   assign req_if.ready  = (state_ff == ST_IDLE);
   assign accept        = req_if.valid && req_if.ready;
   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      ch_in     = ch_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      cur_y_in  = cur_y_ff;
      cur_x_in  = cur_x_ff;
      cnt_r_in  = cnt_r_ff;
      cnt_c_in  = cnt_c_ff;
      sweep_in  = sweep_ff;
      side_in   = side_ff;
      boot_in   = boot_ff;
      cell_in   = cell_ff;
      rsp_data_in = rsp_data_ff;
      load_rsp  = 1'b0;
      finish    = 1'b0;
      go_scroll = 1'b0;
      ny        = cur_y_ff;
      nx        = cur_x_ff;
      mem_we    = 1'b0;
      mem_waddr = cell_addr(cur_y_ff, cur_x_ff);
      mem_wdata = CH_SPACE;
      // The read of a read-cell command is issued as the word is taken.
      mem_raddr = cell_addr(row_c, col_c);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_if.payload.command;
               ch_in    = req_if.payload.char_code;
               row_in   = row_c;
               col_in   = col_c;
               cur_y_in = cy_c;
               cur_x_in = cx_c;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cmd_ff)
               CMD_WRITE_CHAR: begin
                  finish = 1'b1;
                  if (ch_ff == CH_CR) begin
                     nx = '0;
                  end else if (ch_ff == CH_LF) begin
                     nx = '0;
                     if (cur_y_ff == last_row) begin
                        go_scroll = csr.scroll_enable;
                     end else begin
                        ny = cur_y_ff + 1'b1;
                     end
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = ch_ff;
                     if (cur_x_ff == last_col) begin
                        nx = '0;
                        if (cur_y_ff == last_row) begin
                           if (csr.scroll_enable) begin
                              go_scroll = 1'b1;
                           end else begin
                              nx = last_col;
                           end
                        end else begin
                           ny = cur_y_ff + 1'b1;
                        end
                     end else begin
                        nx = cur_x_ff + 1'b1;
                     end
                  end
               end
               CMD_MOVE: begin
                  finish = 1'b1;
                  ny = row_ff;
                  nx = col_ff;
               end
               CMD_CLEAR_EOL: begin
                  cnt_r_in = cur_y_ff;
                  cnt_c_in = cur_x_ff;
                  state_in = ST_BLANK;
               end
               CMD_ERASE: begin
                  sweep_in = '0;
                  state_in = ST_CLEAR;
               end
               CMD_BOX: begin
                  phase_in = BX_VERT;
                  cnt_r_in = '0;
                  side_in  = 1'b0;
                  state_in = ST_BOX;
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
            cur_y_in = ny;
            cur_x_in = nx;
            cell_in  = (cmd_ff == CMD_READ) ? mem_rdata : '0;
            if (go_scroll) begin
               cnt_c_in = '0;
               if (last_row == '0) begin
                  cnt_r_in = '0;
                  state_in = ST_BLANK;
               end else begin
                  cnt_r_in = '0;
                  state_in = ST_SCR_RD;
               end
            end else if (finish) begin
               if (out_free) begin
                  load_rsp = 1'b1;
                  rsp_data_in.cell_value = cell_in;
                  rsp_data_in.cursor_row = ROW_W'(ny);
                  rsp_data_in.cursor_col = COL_W'(nx);
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCR_RD: begin
            mem_raddr = cell_addr(cnt_r_ff + 1'b1, cnt_c_ff);
            state_in  = ST_SCR_WR;
         end
         ST_SCR_WR: begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(cnt_r_ff, cnt_c_ff);
            mem_wdata = mem_rdata;
            state_in  = ST_SCR_RD;
            if (cnt_c_ff == last_col) begin
               cnt_c_in = '0;
               cnt_r_in = cnt_r_ff + 1'b1;
               if (RW'(cnt_r_ff + 1'b1) == last_row) begin
                  state_in = ST_BLANK;
               end
            end else begin
               cnt_c_in = cnt_c_ff + 1'b1;
            end
         end
         ST_BLANK: begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(cnt_r_ff, cnt_c_ff);
            mem_wdata = CH_SPACE;
            if (cnt_c_ff == last_col) begin
               state_in = ST_DONE;
            end else begin
               cnt_c_in = cnt_c_ff + 1'b1;
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = CH_SPACE;
            if (sweep_ff == LAST_A) begin
               boot_in  = 1'b0;
               state_in = boot_ff ? ST_IDLE : ST_DONE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_BOX: begin
            mem_we = 1'b1;
            unique case (phase_ff)
               BX_VERT: begin
                  mem_waddr = cell_addr(cnt_r_ff, side_ff ? last_col : '0);
                  mem_wdata = BOX_VLINE;
                  side_in   = !side_ff;
                  if (side_ff) begin
                     if (cnt_r_ff == last_row) begin
                        cnt_c_in = '0;
                        phase_in = BX_HORZ;
                     end else begin
                        cnt_r_in = cnt_r_ff + 1'b1;
                     end
                  end
               end
               BX_HORZ: begin
                  mem_waddr = cell_addr(side_ff ? last_row : '0, cnt_c_ff);
                  mem_wdata = BOX_HLINE;
                  side_in   = !side_ff;
                  if (side_ff) begin
                     if (cnt_c_ff == last_col) begin
                        phase_in = BX_UL;
                     end else begin
                        cnt_c_in = cnt_c_ff + 1'b1;
                     end
                  end
               end
               BX_UL: begin
                  mem_waddr = cell_addr('0, '0);
                  mem_wdata = BOX_UL;
                  phase_in  = BX_UR;
               end
               BX_UR: begin
                  mem_waddr = cell_addr('0, last_col);
                  mem_wdata = BOX_UR;
                  phase_in  = BX_LL;
               end
               BX_LL: begin
                  mem_waddr = cell_addr(last_row, '0);
                  mem_wdata = BOX_LL;
                  phase_in  = BX_LR;
               end
               BX_LR: begin
                  mem_waddr = cell_addr(last_row, last_col);
                  mem_wdata = BOX_LR;
                  state_in  = ST_DONE;
               end
               default: begin
                  mem_we   = 1'b0;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (out_free) begin
               load_rsp = 1'b1;
               rsp_data_in.cell_value = cell_ff;
               rsp_data_in.cursor_row = ROW_W'(cur_y_ff);
               rsp_data_in.cursor_col = COL_W'(cur_x_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         boot_ff      <= 1'b1;
         cur_y_ff     <= '0;
         cur_x_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= BX_VERT;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         boot_ff      <= boot_in;
         cur_y_ff     <= cur_y_in;
         cur_x_ff     <= cur_x_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      ch_ff       <= ch_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      cnt_r_ff    <= cnt_r_in;
      cnt_c_ff    <= cnt_c_in;
      side_ff     <= side_in;
      cell_ff     <= cell_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A taken word always starts its work in the next cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted word did not enter execution");

   // Each scroll write must follow the read of the row below it.
   a_scroll_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCR_WR |-> $past(state_ff) == ST_SCR_RD)
      else $error("scroll write without preceding read");

   // The store is never written while waiting for a word or for the receiver.
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff != ST_IDLE && state_ff != ST_DONE)
      else $error("store written outside a command");

   // No word is taken until the power-up blanking pass has finished.
   a_boot_blocks: assert property (@(posedge clock) disable iff (reset)
      boot_ff |-> !req_if.ready)
      else $error("input ready during power-up blanking");

endmodule
